>>> design/tab_to_space_expander_assert.svh
// Assertion macros shared by the tab expander checker.
// Needs nothing else; include by bare file name.
`ifndef TAB_TO_SPACE_EXPANDER_ASSERT_SVH
`define TAB_TO_SPACE_EXPANDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tab_to_space_expander check failed");

// Consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tab_to_space_expander check failed");

`endif

>>> design/tts_pkg.sv
// Package for the tab expander: payload structs, character codes,
// register indexes and the remainder unit status. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  // Character codes.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Item operations.
  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIFORM  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MULTIPLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEADING  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT    = 3'd4;

  localparam logic [11:0] UNIFORM_RESET = 12'd8;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  char_byte;
    logic [5:0]  stop_index;
    logic [15:0] stop_column;
  } tts_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] out_count;
  } tts_result_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [11:0] rem;
  } rem_status_t;

endpackage

`default_nettype wire

>>> design/tts_rem.sv
// Iterative remainder unit: dividend modulo a 12-bit divisor, one bit a cycle.
// Depends on tts_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module tts_rem #(
  parameter int DIVIDEND_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [11:0]              divisor,
  output tts_pkg::rem_status_t          status
);

  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  logic                     busy;
  logic                     done;
  logic [CNT_W-1:0]         cnt;
  logic [DIVIDEND_BITS-1:0] shreg;
  logic [11:0]              rem;
  logic [11:0]              div_r;
  logic [12:0]              trial;
  logic [12:0]              trial_sub;
  logic [11:0]              rem_next;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial     = {rem, shreg[DIVIDEND_BITS-1]};
    trial_sub = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_next = trial_sub[11:0];
    end else begin
      rem_next = trial[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      div_r <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.rem  = rem;

endmodule

`default_nettype wire

>>> design/tab_to_space_expander.sv
// Top level of the tab expander: sequencer, column state, stop table memory.
// Depends on tts_pkg and tts_rem.
//
//   Channel  Signals                                  Moves
//   item     item_valid, item_ready, item             one byte or one stop write
//   result   result_valid, result_ready, result       byte plus repeat count
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// Ordinary bytes, newlines, backspaces and stop writes are answered straight from idle.
// A tab with a nonzero uniform width goes through the bit-serial remainder unit.
// Table mode scans one entry per cycle, and a tab past the last stop adds the
// remainder pass when a multiple or repeat width is set.
// Synchronous reset clears the column and non-blank flag and restores the registers;
// stop table contents are undefined until written. A stalled result blocks new items.

`timescale 1ns / 1ps
`default_nettype none

module tab_to_space_expander #(
  parameter int MAX_STOPS   = 64,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output      logic                                item_ready,
  input  wire tts_pkg::tts_item_t                  item,
  output      logic                                result_valid,
  input  wire logic                                result_ready,
  output      tts_pkg::tts_result_t                result,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [tts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Table address width, effective stop count width, compare width.
  localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int NW    = ($clog2(MAX_STOPS + 1) > 7) ? $clog2(MAX_STOPS + 1) : 7;
  localparam int CMP_W = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;
  localparam int TW    = CMP_W + 1;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_MOD    = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  // Configuration registers.
  logic [11:0] uniform_width;
  logic [11:0] multiple_width;
  logic [11:0] repeat_width;
  logic        leading_only;
  logic [6:0]  stop_count;

  logic [1:0]             state, state_next;
  logic [COLUMN_BITS-1:0] column, column_next;
  logic                   nonblank_seen, nonblank_next;
  logic [IDX_W-1:0]       probe, probe_next, rd_addr;
  logic [TW-1:0]          target, target_next;
  logic [11:0]            w_sel;

  logic [15:0] stop_mem [MAX_STOPS];
  logic [15:0] rd_data;

  logic                   accept;
  logic                   is_tab;
  logic                   wr_en;
  logic [NW-1:0]          wr_index;
  logic [NW-1:0]          n_eff;
  logic                   entry_hit;
  logic                   probe_last;

  logic                   mod_start;
  logic [COLUMN_BITS-1:0] mod_dividend;
  logic [11:0]            mod_divisor;
  tts_pkg::rem_status_t   rem_status;

  logic [COLUMN_BITS-1:0] pl_last;
  logic [COLUMN_BITS-1:0] t_sat;
  logic [COLUMN_BITS-1:0] diff;
  logic [CMP_W-1:0]       diff_w;
  logic [15:0]            cnt16;

  logic                 res_load;
  tts_pkg::tts_result_t res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uniform_width  <= tts_pkg::UNIFORM_RESET;
      multiple_width <= '0;
      repeat_width   <= '0;
      leading_only   <= 1'b0;
      stop_count     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tts_pkg::REG_UNIFORM:  uniform_width  <= cfg_data;
        tts_pkg::REG_MULTIPLE: multiple_width <= cfg_data;
        tts_pkg::REG_REPEAT:   repeat_width   <= cfg_data;
        tts_pkg::REG_LEADING:  leading_only   <= cfg_data[0];
        tts_pkg::REG_COUNT:    stop_count     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // A new item is taken only when the sequencer is idle and the result
  // register is empty or being emptied in the same cycle, so any result
  // produced for this item always finds the register free.
  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;
  assign is_tab     = (item.opcode == tts_pkg::OP_CHAR) && (item.char_byte == tts_pkg::CH_TAB);

  // Stop table write; indexes beyond the table depth are dropped.
  assign wr_index = NW'(item.stop_index);
  assign wr_en    = accept && (item.opcode == tts_pkg::OP_WRITE) &&
                    (wr_index < NW'(MAX_STOPS));

  // Stop counts above the table depth act as the full table.
  assign n_eff = (NW'(stop_count) > NW'(MAX_STOPS)) ? NW'(MAX_STOPS) : NW'(stop_count);

  // While idle, entry zero is prefetched so the scan can start at once.
  // During the scan, rd_data holds entry probe and the next one is fetched.
  assign rd_addr = (state == S_SEARCH) ? probe + IDX_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stop_mem[wr_index[IDX_W-1:0]] <= item.stop_column;
    end
    rd_data <= stop_mem[rd_addr];
  end

  assign entry_hit  = CMP_W'(rd_data) > CMP_W'(column);
  assign probe_last = (NW'(probe) + NW'(1)) == n_eff;

  // Past the last stop the scan leaves the last entry in rd_data; with an
  // empty table the last stop counts as column zero.
  assign pl_last = (state == S_SEARCH) ? COLUMN_BITS'(rd_data) : '0;

  tts_rem #(
    .DIVIDEND_BITS (COLUMN_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .status   (rem_status)
  );

  // Space count for a finished tab: target clamped to the column range,
  // then the distance limited to what out_count can carry.
  always_comb begin
    t_sat  = (target > TW'(COL_MAX)) ? COL_MAX : target[COLUMN_BITS-1:0];
    diff   = t_sat - column;
    diff_w = CMP_W'(diff);
    if (diff_w > CMP_W'(tts_pkg::COUNT_MAX)) begin
      cnt16 = tts_pkg::COUNT_MAX;
    end else begin
      cnt16 = diff_w[15:0];
    end
  end

  always_comb begin
    state_next    = state;
    probe_next    = probe;
    target_next   = target;
    column_next   = column;
    nonblank_next = nonblank_seen;
    mod_start     = 1'b0;
    mod_dividend  = column;
    mod_divisor   = uniform_width;
    res_load      = 1'b0;
    res_next      = '0;

    unique case (state)
      S_IDLE: begin
        probe_next = '0;
        if (accept) begin
          if (item.opcode == tts_pkg::OP_WRITE) begin
            res_load = 1'b1;
          end else if (is_tab) begin
            if (uniform_width != '0) begin
              mod_start  = 1'b1;
              state_next = S_MOD;
            end else if (n_eff != '0) begin
              state_next = S_SEARCH;
            end else if (multiple_width != '0) begin
              mod_start   = 1'b1;
              mod_divisor = multiple_width;
              state_next  = S_MOD;
            end else if (repeat_width != '0) begin
              mod_start    = 1'b1;
              mod_divisor  = repeat_width;
              mod_dividend = column - pl_last;
              state_next   = S_MOD;
            end else begin
              target_next = TW'(column) + TW'(1);
              state_next  = S_DONE;
            end
          end else begin
            // Newline, backspace and ordinary bytes pass straight through.
            res_load           = 1'b1;
            res_next.out_byte  = item.char_byte;
            res_next.out_count = 16'd1;
            priority if (item.char_byte == tts_pkg::CH_NL) begin
              column_next   = '0;
              nonblank_next = 1'b0;
            end else if (item.char_byte == tts_pkg::CH_BS) begin
              if (column != '0) begin
                column_next = column - COLUMN_BITS'(1);
              end
            end else begin
              if (item.char_byte != tts_pkg::CH_SP) begin
                nonblank_next = 1'b1;
              end
              if (column != COL_MAX) begin
                column_next = column + COLUMN_BITS'(1);
              end
            end
          end
        end
      end

      S_SEARCH: begin
        probe_next = probe + IDX_W'(1);
        if (entry_hit) begin
          target_next = TW'(rd_data);
          state_next  = S_DONE;
        end else if (probe_last) begin
          if (multiple_width != '0) begin
            mod_start   = 1'b1;
            mod_divisor = multiple_width;
            state_next  = S_MOD;
          end else if (repeat_width != '0) begin
            mod_start    = 1'b1;
            mod_divisor  = repeat_width;
            mod_dividend = column - pl_last;
            state_next   = S_MOD;
          end else begin
            target_next = TW'(column) + TW'(1);
            state_next  = S_DONE;
          end
        end
      end

      S_MOD: begin
        if (rem_status.done) begin
          target_next = TW'(column) + TW'(w_sel - rem_status.rem);
          state_next  = S_DONE;
        end
      end

      S_DONE: begin
        res_load    = 1'b1;
        column_next = column + COLUMN_BITS'(cnt16);
        if (leading_only && nonblank_seen) begin
          res_next.out_byte  = tts_pkg::CH_TAB;
          res_next.out_count = 16'd1;
        end else begin
          res_next.out_byte  = tts_pkg::CH_SP;
          res_next.out_count = cnt16;
        end
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      column        <= '0;
      nonblank_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      column        <= column_next;
      nonblank_seen <= nonblank_next;
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe  <= probe_next;
    target <= target_next;
    if (mod_start) begin
      w_sel <= mod_divisor;
    end
    if (res_load) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> design/tts_checker.sv
// Port-level checker for the tab expander, bound to the top level.
// Depends on tts_pkg and tab_to_space_expander_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "tab_to_space_expander_assert.svh"

module tts_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 item_valid,
  input wire logic                 item_ready,
  input wire tts_pkg::tts_item_t   item,
  input wire logic                 result_valid,
  input wire logic                 result_ready,
  input wire tts_pkg::tts_result_t result
);

  logic       item_xfer;
  logic       is_write;
  logic       is_tab;
  logic       is_echo;
  logic       res_stall;
  logic       res_empty;
  logic       echo_ok;
  logic [7:0] last_char;

  assign item_xfer = item_valid && item_ready;
  assign is_write  = item.opcode == tts_pkg::OP_WRITE;
  assign is_tab    = (item.opcode == tts_pkg::OP_CHAR) && (item.char_byte == tts_pkg::CH_TAB);
  assign is_echo   = !is_write && !is_tab;
  assign res_stall = result_valid && !result_ready;
  assign res_empty = result_valid && (result.out_count == 16'd0) && (result.out_byte == 8'd0);

  // Byte offered in the previous cycle, for the echo check.
  always_ff @(posedge clk) begin
    last_char <= item.char_byte;
  end

  assign echo_ok = result_valid && (result.out_count == 16'd1) && (result.out_byte == last_char);

  // A result that is not taken stays put.
  `TTS_ASSERT_NEXT(a_result_hold, clk, rst, res_stall, result_valid && $stable(result))

  // No item is taken while a result is stuck in the output register.
  `TTS_ASSERT_SAME(a_no_overrun, clk, rst, item_ready, !result_valid || result_ready)

  // A table write answers in the next cycle with an empty result.
  `TTS_ASSERT_NEXT(a_write_result, clk, rst, item_xfer && is_write, res_empty)

  // Any byte other than a tab is echoed once in the next cycle.
  `TTS_ASSERT_NEXT(a_echo, clk, rst, item_xfer && is_echo, echo_ok)

  // A tab occupies the sequencer for at least the following cycle.
  `TTS_ASSERT_NEXT(a_tab_busy, clk, rst, item_xfer && is_tab, !item_ready)

endmodule

bind tab_to_space_expander tts_checker u_tts_checker (.*);

`default_nettype wire
